// ----- rtl/ipv4_cidr_validator_assert.svh -----
// Assertion macros used by the address validator RTL.
`ifndef IPV4_CIDR_VALIDATOR_ASSERT_SVH
`define IPV4_CIDR_VALIDATOR_ASSERT_SVH

// When cond holds, prop must hold in the same cycle.
`define ICV_ASSERT_SAME(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// When cond holds, prop must hold in the following cycle.
`define ICV_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- rtl/icv_pkg.sv -----
// Shared types and constants for the IPv4 address and CIDR validator.
package icv_pkg;

   // Character codes the parser recognizes.
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   // Limits of the address and prefix grammar.
   localparam logic [11:0] OCTET_MAX        = 12'd255;
   localparam logic [1:0]  OCTET_DIGITS_MAX = 2'd3;
   localparam logic [2:0]  OCTETS_NEEDED    = 3'd4;
   localparam logic [2:0]  OCTET_COUNT_SAT  = 3'd5;
   localparam logic [5:0]  PREFIX_MAX       = 6'd32;
   localparam logic [8:0]  PREFIX_SAT      = 9'd33;

   // Parser state carried from one character to the next.
   typedef struct packed {
      logic       in_prefix;
      logic [7:0] octet_value;
      logic [1:0] octet_digits;
      logic [2:0] octet_count;
      logic       after_dot;
      logic [5:0] prefix_value;
      logic       prefix_digit_seen;
      logic       bad;
   } icv_state_type;

   // One result beat.
   typedef struct packed {
      logic       valid_res;
      logic [5:0] prefix_len;
   } icv_result_type;

endpackage

// ----- rtl/icv_parse.sv -----
// Next-state and result logic for one character of address text.
module icv_parse (
   input  logic [7:0]             text_byte,
   input  icv_pkg::icv_state_type state_cur,
   output icv_pkg::icv_state_type state_nxt,
   output logic                   is_term,
   output icv_pkg::icv_result_type result
);
   import icv_pkg::*;

   logic        is_digit;
   logic [3:0]  digit;
   logic [11:0] oct_acc;
   logic [8:0]  pfx_acc;
   logic [2:0]  count_inc;

   // Character class and digit value; the low nibble of '0'..'9' is the digit.
   assign is_term  = (text_byte == CHAR_NUL);
   assign is_digit = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
   assign digit    = text_byte[3:0];

   // Decimal accumulation for the octet and the prefix.
   assign oct_acc = 12'(state_cur.octet_value) * 12'd10 + 12'(digit);
   assign pfx_acc = 9'(state_cur.prefix_value) * 9'd10 + 9'(digit);

   // Octet count after closing the current octet, held at saturation.
   assign count_inc = (state_cur.octet_count < OCTET_COUNT_SAT) ?
                      state_cur.octet_count + 3'd1 : state_cur.octet_count;

   // State update for one character; a terminator clears the state.
   always_comb begin
      state_nxt = state_cur;
      if (is_term) begin
         state_nxt = '0;
      end else if (!state_cur.bad) begin
         if (state_cur.in_prefix) begin
            if (is_digit) begin
               state_nxt.prefix_value      = (pfx_acc > PREFIX_SAT) ?
                                             PREFIX_SAT[5:0] : pfx_acc[5:0];
               state_nxt.prefix_digit_seen = 1'b1;
            end else begin
               state_nxt.bad = 1'b1;
            end
         end else if (is_digit) begin
            state_nxt.after_dot = 1'b0;
            if (state_cur.octet_digits >= OCTET_DIGITS_MAX) begin
               state_nxt.bad = 1'b1;
            end else begin
               state_nxt.octet_digits = state_cur.octet_digits + 2'd1;
               if (oct_acc > OCTET_MAX) begin
                  state_nxt.bad         = 1'b1;
                  state_nxt.octet_value = OCTET_MAX[7:0];
               end else begin
                  state_nxt.octet_value = oct_acc[7:0];
               end
            end
         end else if (text_byte == CHAR_DOT) begin
            if (state_cur.octet_digits == 2'd0) begin
               state_nxt.bad = 1'b1;
            end else begin
               state_nxt.octet_count  = count_inc;
               state_nxt.octet_value  = '0;
               state_nxt.octet_digits = '0;
               state_nxt.after_dot    = 1'b1;
            end
         end else if (text_byte == CHAR_SLASH) begin
            // A slash closes an open octet; a dot just before it is tolerated.
            if (state_cur.octet_digits != 2'd0) begin
               state_nxt.octet_count  = count_inc;
               state_nxt.octet_value  = '0;
               state_nxt.octet_digits = '0;
               if (count_inc != OCTETS_NEEDED) begin
                  state_nxt.bad = 1'b1;
               end
            end else if (state_cur.octet_count != OCTETS_NEEDED) begin
               state_nxt.bad = 1'b1;
            end
            state_nxt.after_dot = 1'b0;
            state_nxt.in_prefix = 1'b1;
         end else begin
            state_nxt.bad = 1'b1;
         end
      end
   end

   // Verdict on the terminator.
   always_comb begin
      result = '0;
      if (!state_cur.bad) begin
         if (state_cur.in_prefix) begin
            if (state_cur.prefix_digit_seen && (state_cur.prefix_value <= PREFIX_MAX)) begin
               result.valid_res  = 1'b1;
               result.prefix_len = state_cur.prefix_value;
            end
         end else if (!state_cur.after_dot && (state_cur.octet_digits != 2'd0) &&
                      (count_inc == OCTETS_NEEDED)) begin
            result.valid_res  = 1'b1;
            result.prefix_len = PREFIX_MAX;
         end
      end
   end

endmodule

// ----- rtl/ipv4_cidr_validator.sv -----
// A terminator beat passes through the input register and then the result register to the ports.
// Throughput: one character beat per cycle; the input register parts from the result
// register, so a stalled result holds only a terminator, other characters keep flowing.
// The parser state register updates once per character; the result is set on a zero byte.
// Reset (synchronous, active high) empties both registers and clears the parser state.
`include "ipv4_cidr_validator_assert.svh"

module ipv4_cidr_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_valid_res,
   output logic [5:0] rsp_prefix_len
);
   import icv_pkg::*;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff, in_byte_in;
   icv_state_type  state_ff, state_in, state_nxt;
   logic           rsp_valid_ff, rsp_valid_in;
   icv_result_type rsp_res_ff, rsp_res_in, result;
   logic           is_term;
   logic           advance;
   logic           req_accept;

   // Per-character parser logic.
   icv_parse u_parse (
      .text_byte (in_byte_ff),
      .state_cur (state_ff),
      .state_nxt (state_nxt),
      .is_term   (is_term),
      .result    (result)
   );

   // A held character moves on unless it is a terminator facing a stalled result.
   assign advance    = in_valid_ff && (!is_term || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   // Next values of the input, state and result registers.
   always_comb begin
      in_valid_in  = req_accept || (in_valid_ff && !advance);
      in_byte_in   = req_accept ? req_text_byte : in_byte_ff;
      state_in     = advance ? state_nxt : state_ff;
      rsp_valid_in = (advance && is_term) || (rsp_valid_ff && rsp_stall);
      rsp_res_in   = (advance && is_term) ? result : rsp_res_ff;
   end

   // Registers; control state is reset, payload is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_byte_ff <= in_byte_in;
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_valid_res  = rsp_res_ff.valid_res;
   assign rsp_prefix_len = rsp_res_ff.prefix_len;

   // Checks on the parser and result path.
   `ICV_ASSERT_SAME(a_invalid_zero_len, clock, reset,
      rsp_valid_ff && !rsp_res_ff.valid_res, rsp_res_ff.prefix_len == 6'd0,
      "invalid result carries a nonzero prefix length")
   `ICV_ASSERT_SAME(a_valid_len_range, clock, reset,
      rsp_valid_ff && rsp_res_ff.valid_res, rsp_res_ff.prefix_len <= PREFIX_MAX,
      "valid result carries a prefix length above 32")
   `ICV_ASSERT_NEXT(a_state_cleared, clock, reset,
      advance && is_term, state_ff == '0 && rsp_valid_ff,
      "terminator did not clear the parser state or post a result")

endmodule
